[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DSLT_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("dslt assertion failed");

// next-cycle implication
`define DSLT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("dslt assertion failed");

`endif

[rtl/dslt_pkg.sv]
// ----------------------------------------------------------------------------
// dslt_pkg
// types, codes and helpers for the delay search and lock tracker
// ----------------------------------------------------------------------------
`default_nettype none

package dslt_pkg;

	typedef enum logic [4:0] {
		M_STOP   = 5'b00001,
		M_SEARCH = 5'b00010,
		M_FOUND  = 5'b00100,
		M_LOCK   = 5'b01000,
		M_LOST   = 5'b10000
	} mode_t;

	localparam logic [2:0] CODE_STOP   = 3'd0;
	localparam logic [2:0] CODE_SEARCH = 3'd1;
	localparam logic [2:0] CODE_FOUND  = 3'd2;
	localparam logic [2:0] CODE_LOCK   = 3'd3;
	localparam logic [2:0] CODE_LOST   = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE      = 3'd0,
		REG_SNR_FOUND   = 3'd1,
		REG_SNR_LOST    = 3'd2,
		REG_HOLD_COUNTS = 3'd3,
		REG_AMP_LIMITS  = 3'd4,
		REG_STEP_SIZE   = 3'd5,
		REG_FACTOR      = 3'd6,
		REG_GAIN_LIMIT  = 3'd7
	} reg_idx_t;

	localparam logic [15:0] FACTOR_RESET = 16'd4096;

	typedef struct packed {
		logic [15:0]        snr;
		logic signed [15:0] delay_error;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] move;
		logic [2:0]         tracker_state;
	} out_item_t;

	// decoded configuration handed to the tracker core
	typedef struct packed {
		logic               enable;
		logic [15:0]        snr_found;
		logic [15:0]        snr_lost;
		logic [15:0]        hold_search;
		logic [15:0]        hold_found;
		logic [15:0]        hold_lost;
		logic [15:0]        amp_min;
		logic [15:0]        amp_max;
		logic signed [15:0] step_size;
		logic [15:0]        factor;
		logic [15:0]        gain;
		logic [15:0]        max_move;
	} cfg_t;

	// register contents after reset: all zero except the growth factor
	function automatic cfg_t cfg_reset_value();
		cfg_t c;
		c = '0;
		c.factor = FACTOR_RESET;
		return c;
	endfunction

	localparam cfg_t CFG_RESET = cfg_reset_value();

	// negate with -32768 going to 32767
	function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
		return (v == 16'sh8000) ? 16'sh7fff : -v;
	endfunction

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		case (m)
			M_STOP:   c = CODE_STOP;
			M_SEARCH: c = CODE_SEARCH;
			M_FOUND:  c = CODE_FOUND;
			M_LOCK:   c = CODE_LOCK;
			M_LOST:   c = CODE_LOST;
			default:  c = CODE_STOP;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/dslt_core.sv]
// ----------------------------------------------------------------------------
// dslt_core
// tracker state registers and the per-item next-state and move logic
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dslt_core
	import dslt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire cfg_t      cfg,
	input  wire in_item_t  item,
	output out_item_t      result
);

	mode_t              mode_q;
	logic [15:0]        dwell_q;
	logic signed [15:0] step_q;
	logic signed [23:0] cum_q;
	logic [15:0]        amp_q;
	logic               neg_q;

	mode_t              mode_pre, mode_nxt;
	logic [15:0]        dwell_pre, dwell_nxt, dwell_inc;
	logic signed [15:0] step_pre, step_nxt, base_step, move;
	logic signed [23:0] cum_pre, cum_nxt, cum_sat;
	logic [15:0]        amp_pre, amp_nxt, amp_grow, amp_sel, amp_cap;
	logic               neg_pre, neg_nxt;

	logic signed [24:0] cum_sum;
	logic [24:0]        cum_mag;
	logic               reverse;
	logic [31:0]        amp_prod;

	logic signed [32:0] lock_prod;
	logic signed [24:0] lock_m, lock_lim, lock_c;
	logic signed [15:0] lock_move;

	// enable and start-up handling ahead of the per-mode update
	always_comb begin
		mode_pre  = mode_q;
		dwell_pre = dwell_q;
		step_pre  = step_q;
		cum_pre   = cum_q;
		amp_pre   = amp_q;
		neg_pre   = neg_q;
		if (!cfg.enable) begin
			mode_pre = M_STOP;
		end else if (mode_q == M_STOP) begin
			mode_pre  = M_SEARCH;
			neg_pre   = 1'b0;
			dwell_pre = '0;
			step_pre  = cfg.step_size;
			cum_pre   = '0;
			amp_pre   = cfg.amp_min;
		end
	end

	assign base_step = neg_pre ? neg_sat16(cfg.step_size) : cfg.step_size;
	assign dwell_inc = (dwell_pre == 16'hffff) ? dwell_pre : dwell_pre + 16'd1;

	// search sweep arithmetic
	assign cum_sum = {cum_pre[23], cum_pre} + {{9{step_pre[15]}}, step_pre};
	always_comb begin
		if (cum_sum[24] != cum_sum[23]) begin
			cum_sat = cum_sum[24] ? 24'sh800000 : 24'sh7fffff;
		end else begin
			cum_sat = cum_sum[23:0];
		end
	end
	assign cum_mag  = cum_sat[23] ? (25'd0 - {1'b1, cum_sat}) : {1'b0, cum_sat};
	assign reverse  = (cum_mag >= {9'd0, amp_pre});
	assign amp_prod = {16'd0, amp_pre} * {16'd0, cfg.factor};
	assign amp_grow = (amp_prod[31:28] != 4'd0) ? 16'hffff : amp_prod[27:12];
	assign amp_sel  = reverse ? amp_grow : amp_pre;
	assign amp_cap  = (amp_sel > cfg.amp_max) ? cfg.amp_max : amp_sel;

	// lock move: floor((delay * gain) / 256), clamped to +-max_move, then to 16 bits
	assign lock_prod = item.delay_error * $signed({1'b0, cfg.gain});
	assign lock_m    = $signed(lock_prod[32:8]);
	assign lock_lim  = $signed({9'd0, cfg.max_move});
	always_comb begin
		if (lock_m > lock_lim) begin
			lock_c = lock_lim;
		end else if (lock_m < -lock_lim) begin
			lock_c = -lock_lim;
		end else begin
			lock_c = lock_m;
		end
		if (lock_c > 25'sd32767) begin
			lock_move = 16'sh7fff;
		end else if (lock_c < -25'sd32768) begin
			lock_move = 16'sh8000;
		end else begin
			lock_move = lock_c[15:0];
		end
	end

	always_comb begin
		mode_nxt  = mode_pre;
		dwell_nxt = dwell_pre;
		step_nxt  = step_pre;
		cum_nxt   = cum_pre;
		amp_nxt   = amp_pre;
		neg_nxt   = neg_pre;
		move      = '0;
		case (mode_pre)
			M_STOP: begin
			end
			M_SEARCH: begin
				if (item.snr > cfg.snr_found) begin
					mode_nxt  = M_FOUND;
					dwell_nxt = '0;
				end else if (dwell_inc < cfg.hold_search) begin
					dwell_nxt = dwell_inc;
				end else begin
					dwell_nxt = '0;
					move      = step_pre;
					cum_nxt   = cum_sat;
					amp_nxt   = amp_cap;
					step_nxt  = reverse ? neg_sat16(step_pre) : step_pre;
				end
			end
			M_FOUND: begin
				if (item.snr < cfg.snr_lost) begin
					mode_nxt  = M_SEARCH;
					dwell_nxt = '0;
					step_nxt  = base_step;
				end else begin
					dwell_nxt = dwell_inc;
					if (dwell_inc >= cfg.hold_found) begin
						mode_nxt = M_LOCK;
					end
				end
			end
			M_LOCK: begin
				if (item.snr < cfg.snr_lost) begin
					mode_nxt  = M_LOST;
					dwell_nxt = '0;
				end else begin
					move = lock_move;
				end
			end
			M_LOST: begin
				if (item.snr > cfg.snr_found) begin
					mode_nxt = M_LOCK;
				end else begin
					dwell_nxt = dwell_inc;
					if (dwell_inc >= cfg.hold_lost) begin
						mode_nxt  = M_SEARCH;
						dwell_nxt = '0;
						step_nxt  = base_step;
						cum_nxt   = '0;
						amp_nxt   = cfg.amp_min;
						neg_nxt   = !neg_pre;
					end
				end
			end
			default: begin
				mode_nxt = M_STOP;
			end
		endcase
	end

	assign result.move          = move;
	assign result.tracker_state = mode_code(mode_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_STOP;
			dwell_q <= '0;
			step_q  <= '0;
			cum_q   <= '0;
			amp_q   <= '0;
			neg_q   <= 1'b0;
		end else if (adv) begin
			mode_q  <= mode_nxt;
			dwell_q <= dwell_nxt;
			step_q  <= step_nxt;
			cum_q   <= cum_nxt;
			amp_q   <= amp_nxt;
			neg_q   <= neg_nxt;
		end
	end

	`DSLT_ASSERT_NEXT(a_disable_stops, adv && !cfg.enable, mode_q == M_STOP)
	`DSLT_ASSERT_NEXT(a_start_unnegated, adv && cfg.enable && (mode_q == M_STOP), !neg_q)
	`DSLT_ASSERT_NEXT(a_hold_when_idle, !adv, $stable(mode_q) && $stable(dwell_q) && $stable(cum_q))
	`DSLT_ASSERT_SAME(a_move_only_moving, (move != 16'sd0),
		(mode_pre == M_LOCK) || (mode_pre == M_SEARCH))

endmodule

`default_nettype wire

[rtl/delay_search_lock_tracker_top.sv]
// ----------------------------------------------------------------------------
// delay_search_lock_tracker_top
// delay search and lock tracker with config registers, input and result stages
// ----------------------------------------------------------------------------
// One item per clock cycle sustained while out_stall stays low; each item passes
// through the input register, then the result register. The tracker state loop
// (mode, dwell, sweep step, cumulative move, amplitude) closes through the
// combinational next-state logic in dslt_core, which also holds the two
// 16x16 multipliers (amplitude growth and lock gain). Configuration writes are
// always ready and take effect on the next item.
`default_nettype none

module delay_search_lock_tracker_top
	import dslt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t result;
	logic      adv;
	logic      in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE: begin
					cfg_q.enable <= cfg_data[0];
				end
				REG_SNR_FOUND: begin
					cfg_q.snr_found <= cfg_data[15:0];
				end
				REG_SNR_LOST: begin
					cfg_q.snr_lost <= cfg_data[15:0];
				end
				REG_HOLD_COUNTS: begin
					cfg_q.hold_search <= cfg_data[15:0];
					cfg_q.hold_found  <= cfg_data[31:16];
					cfg_q.hold_lost   <= cfg_data[47:32];
				end
				REG_AMP_LIMITS: begin
					cfg_q.amp_min <= cfg_data[15:0];
					cfg_q.amp_max <= cfg_data[31:16];
				end
				REG_STEP_SIZE: begin
					cfg_q.step_size <= $signed(cfg_data[15:0]);
				end
				REG_FACTOR: begin
					cfg_q.factor <= cfg_data[15:0];
				end
				REG_GAIN_LIMIT: begin
					cfg_q.gain     <= cfg_data[15:0];
					cfg_q.max_move <= cfg_data[31:16];
				end
				default: begin
				end
			endcase
		end
	end

	// the input stage moves on whenever the result register is free or being taken
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	dslt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule

`default_nettype wire
